### src/jfve_pkg.sv
`timescale 1ns / 1ps

package jfve_pkg;

    // Parser modes
    typedef enum logic [2:0] {
        MODE_SCAN         = 3'd0,
        MODE_KEY          = 3'd1,
        MODE_AFTER_KEY    = 3'd2,
        MODE_EXPECT_VALUE = 3'd3,
        MODE_SKIP_VALUE   = 3'd4,
        MODE_IN_VALUE     = 3'd5,
        MODE_HEX          = 3'd6
    } mode_t;

    // Result kinds
    localparam logic [1:0] KIND_TITLE      = 2'd0;
    localparam logic [1:0] KIND_EXTRACT    = 2'd1;
    localparam logic [1:0] KIND_LINE_END   = 2'd2;
    localparam logic [1:0] KIND_TITLE_DONE = 2'd3;

    localparam int MAX_RESULTS = 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    localparam logic [3:0] TITLE_LEN   = 4'd5;
    localparam logic [3:0] EXTRACT_LEN = 4'd7;
    localparam logic [3:0] KEY_POS_MAX = 4'd15;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;

    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    typedef struct packed {
        mode_t       mode;
        logic        esc;
        logic [3:0]  key_pos;
        logic        title_alive;
        logic        extract_alive;
        logic        is_extract;
        logic        line_has;
        logic [11:0] hex_acc;
        logic [1:0]  hex_cnt;
    } parse_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } result_t;

    // Results of one input word, items[0] first
    typedef struct packed {
        logic [1:0]    count;
        result_t [2:0] items;
    } step_out_t;

    function automatic logic [7:0] title_char(input logic [3:0] p);
        logic [7:0] c;
        unique case (p)
            4'd0:    c = 8'h74; // t
            4'd1:    c = 8'h69; // i
            4'd2:    c = 8'h74; // t
            4'd3:    c = 8'h6C; // l
            4'd4:    c = 8'h65; // e
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] extract_char(input logic [3:0] p);
        logic [7:0] c;
        unique case (p)
            4'd0:    c = 8'h65; // e
            4'd1:    c = 8'h78; // x
            4'd2:    c = 8'h74; // t
            4'd3:    c = 8'h72; // r
            4'd4:    c = 8'h61; // a
            4'd5:    c = 8'h63; // c
            4'd6:    c = 8'h74; // t
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39) r = {1'b1, 4'(ch - 8'h30)};
        else if (ch >= 8'h61 && ch <= 8'h66) r = {1'b1, 4'(ch - 8'h57)};
        else if (ch >= 8'h41 && ch <= 8'h46) r = {1'b1, 4'(ch - 8'h37)};
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

endpackage

### src/jfve_parser.sv
`timescale 1ns / 1ps

module jfve_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    output jfve_pkg::step_out_t step
);
    import jfve_pkg::*;

    parse_state_t st_reg;
    parse_state_t st_next;
    step_out_t    out_c;
    logic [7:0]   ch;
    logic [1:0]   vkind;
    logic         title_ok;
    logic         extract_ok;
    logic [4:0]   hd;
    logic [15:0]  cp;
    logic [7:0]   esc_byte;

    assign ch         = in_byte;
    assign vkind      = st_reg.is_extract ? KIND_EXTRACT : KIND_TITLE;
    assign title_ok   = (st_reg.key_pos < TITLE_LEN) && (title_char(st_reg.key_pos) == ch);
    assign extract_ok = (st_reg.key_pos < EXTRACT_LEN)
                        && (extract_char(st_reg.key_pos) == ch);
    assign hd         = hex_digit(ch);
    assign cp         = {st_reg.hex_acc, hd[3:0]};

    always_comb
    begin
        priority if (ch == CH_LOW_R) esc_byte = CH_CR;
        else if (ch == CH_LOW_T)     esc_byte = CH_TAB;
        else if (ch == CH_LOW_B)     esc_byte = CH_BS;
        else if (ch == CH_LOW_F)     esc_byte = CH_FF;
        else                         esc_byte = ch;
    end

    always_comb
    begin
        st_next = st_reg;
        out_c   = '0;
        unique case (st_reg.mode)
            MODE_KEY:
            begin
                if (st_reg.esc || (ch != CH_BSLASH && ch != CH_QUOTE))
                begin
                    // key byte, escaped or plain
                    st_next.esc           = 1'b0;
                    st_next.title_alive   = st_reg.title_alive & title_ok;
                    st_next.extract_alive = st_reg.extract_alive & extract_ok;
                    if (st_reg.key_pos < KEY_POS_MAX)
                        st_next.key_pos = st_reg.key_pos + 4'd1;
                end
                else if (ch == CH_BSLASH)
                begin
                    st_next.esc = 1'b1;
                end
                else
                begin
                    st_next.title_alive   = st_reg.title_alive && (st_reg.key_pos == TITLE_LEN);
                    st_next.extract_alive = st_reg.extract_alive
                                            && (st_reg.key_pos == EXTRACT_LEN);
                    st_next.mode          = MODE_AFTER_KEY;
                end
            end
            MODE_AFTER_KEY:
            begin
                if (!is_space(ch))
                    st_next.mode = (ch == CH_COLON) ? MODE_EXPECT_VALUE : MODE_SCAN;
            end
            MODE_EXPECT_VALUE:
            begin
                if (!is_space(ch))
                begin
                    if (ch == CH_QUOTE)
                    begin
                        st_next.esc      = 1'b0;
                        st_next.line_has = 1'b0;
                        if (st_reg.title_alive || st_reg.extract_alive)
                        begin
                            st_next.is_extract = st_reg.extract_alive;
                            st_next.mode       = MODE_IN_VALUE;
                        end
                        else
                        begin
                            st_next.mode = MODE_SKIP_VALUE;
                        end
                    end
                    else
                    begin
                        st_next.mode = MODE_SCAN;
                    end
                end
            end
            MODE_SKIP_VALUE:
            begin
                if (st_reg.esc)             st_next.esc  = 1'b0;
                else if (ch == CH_BSLASH)   st_next.esc  = 1'b1;
                else if (ch == CH_QUOTE)    st_next.mode = MODE_SCAN;
            end
            MODE_IN_VALUE:
            begin
                if (st_reg.esc)
                begin
                    st_next.esc = 1'b0;
                    if (ch == CH_LOW_U)
                    begin
                        st_next.hex_acc = '0;
                        st_next.hex_cnt = '0;
                        st_next.mode    = MODE_HEX;
                    end
                    else if (ch == CH_LOW_N && st_reg.is_extract)
                    begin
                        out_c.count    = 2'd1;
                        out_c.items[0] = '{kind: KIND_LINE_END, data: 8'h00};
                        st_next.line_has = 1'b0;
                    end
                    else
                    begin
                        out_c.count    = 2'd1;
                        out_c.items[0] = '{kind: vkind,
                                          data: (ch == CH_LOW_N) ? CH_LF : esc_byte};
                        if (st_reg.is_extract) st_next.line_has = 1'b1;
                    end
                end
                else if (ch == CH_BSLASH)
                begin
                    st_next.esc = 1'b1;
                end
                else if (ch == CH_QUOTE)
                begin
                    if (!st_reg.is_extract)
                    begin
                        out_c.count    = 2'd1;
                        out_c.items[0] = '{kind: KIND_TITLE_DONE, data: 8'h00};
                    end
                    else if (st_reg.line_has)
                    begin
                        out_c.count    = 2'd1;
                        out_c.items[0] = '{kind: KIND_LINE_END, data: 8'h00};
                        st_next.line_has = 1'b0;
                    end
                    st_next.mode = MODE_SCAN;
                end
                else if (st_reg.is_extract && ch == CH_LF)
                begin
                    out_c.count    = 2'd1;
                    out_c.items[0] = '{kind: KIND_LINE_END, data: 8'h00};
                    st_next.line_has = 1'b0;
                end
                else
                begin
                    out_c.count    = 2'd1;
                    out_c.items[0] = '{kind: vkind, data: ch};
                    if (st_reg.is_extract) st_next.line_has = 1'b1;
                end
            end
            MODE_HEX:
            begin
                if (!hd[4])
                begin
                    // bad digit: drop the whole escape
                    st_next.hex_acc = '0;
                    st_next.hex_cnt = '0;
                    st_next.mode    = MODE_IN_VALUE;
                end
                else if (st_reg.hex_cnt != 2'd3)
                begin
                    st_next.hex_acc = {st_reg.hex_acc[7:0], hd[3:0]};
                    st_next.hex_cnt = st_reg.hex_cnt + 2'd1;
                end
                else
                begin
                    if (cp[15:7] == '0)
                    begin
                        out_c.count    = 2'd1;
                        out_c.items[0] = '{kind: vkind, data: {1'b0, cp[6:0]}};
                    end
                    else if (cp[15:11] == '0)
                    begin
                        out_c.count    = 2'd2;
                        out_c.items[0] = '{kind: vkind, data: UTF8_LEAD2 | {3'b000, cp[10:6]}};
                        out_c.items[1] = '{kind: vkind, data: UTF8_CONT | {2'b00, cp[5:0]}};
                    end
                    else
                    begin
                        out_c.count    = 2'd3;
                        out_c.items[0] = '{kind: vkind, data: UTF8_LEAD3 | {4'h0, cp[15:12]}};
                        out_c.items[1] = '{kind: vkind, data: UTF8_CONT | {2'b00, cp[11:6]}};
                        out_c.items[2] = '{kind: vkind, data: UTF8_CONT | {2'b00, cp[5:0]}};
                    end
                    if (st_reg.is_extract) st_next.line_has = 1'b1;
                    st_next.hex_acc = '0;
                    st_next.hex_cnt = '0;
                    st_next.mode    = MODE_IN_VALUE;
                end
            end
            default:
            begin
                // scanning, and the unused mode code
                st_next.mode = MODE_SCAN;
                if (ch == CH_QUOTE)
                begin
                    st_next.key_pos       = '0;
                    st_next.title_alive   = 1'b1;
                    st_next.extract_alive = 1'b1;
                    st_next.esc           = 1'b0;
                    st_next.mode          = MODE_KEY;
                end
            end
        endcase
    end

    assign step = out_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{mode: MODE_SCAN, default: '0};
        end
        else if (accept)
        begin
            st_reg <= st_next;
        end
    end

endmodule

### src/jfve_res_fifo.sv
`timescale 1ns / 1ps

module jfve_res_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  jfve_pkg::step_out_t step,
    output logic                has_room,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          out_kind,
    output logic [7:0]          out_data,
    output logic                out_last
);
    import jfve_pkg::*;

    typedef struct packed {
        result_t res;
        logic    last;
    } entry_t;

    entry_t                 mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg;
    logic [FIFO_AW-1:0]     wr_ptr_next;
    logic [FIFO_AW-1:0]     rd_ptr_reg;
    logic [FIFO_AW-1:0]     rd_ptr_next;
    logic [FIFO_CW-1:0]     count_reg;
    logic [FIFO_CW-1:0]     count_next;
    logic [1:0]             n_push;
    logic                   pop;

    assign n_push    = push ? step.count : 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    // a full burst of results must fit behind what is queued
    assign has_room  = (count_reg <= FIFO_CW'(FIFO_DEPTH - MAX_RESULTS));

    assign out_kind = mem[rd_ptr_reg].res.kind;
    assign out_data = mem[rd_ptr_reg].res.data;
    assign out_last = mem[rd_ptr_reg].last;

    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(n_push);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
    assign count_next  = count_reg + FIFO_CW'(n_push) - FIFO_CW'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (i < int'(n_push))
            begin
                mem[wr_ptr_reg + FIFO_AW'(i)] <= '{res:  step.items[i],
                                                   last: (i == int'(n_push) - 1)};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (n_push != 2'd0) |-> has_room)
        else $error("results pushed without room");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && n_push == 2'd0) |=> (count_reg == $past(count_reg) - FIFO_CW'(1)))
        else $error("queue count lost track of a pop");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != FIFO_CW'(FIFO_DEPTH)) |->
            (FIFO_AW'(count_reg) == FIFO_AW'(wr_ptr_reg - rd_ptr_reg)))
        else $error("queue pointers disagree with count");

endmodule

### src/json_field_value_extractor_unit.sv
`timescale 1ns / 1ps
// JSON field value extractor.
// Input: one raw JSON byte per word on s_axis (tdata = in_byte).
// Output: decoded value words on m_axis. tuser carries the kind (title byte,
// extract byte, extract line end, title complete), tdata the decoded byte
// (zero for line end and title complete), tlast marks the final word caused
// by one input byte. An input byte may cause zero to three output words.
// Results of an accepted input byte are registered into the result buffer
// and reach the outputs behind any words already queued. Throughput: one
// input byte per cycle as long as the receiver keeps up and each byte gives
// at most one word; the parser state is one register updated per byte.
// Results queue in a four-word buffer. s_axis_tready stays high while at
// most one word is queued, so with the receiver keeping up a byte giving two
// or three words (the last digit of a \u escape) holds off input until at
// most one word is queued again; that buffer depth sets the burst limit.
// When the receiver stalls, queued words hold and input stops once the
// buffer is past one word. Reset clears the parser to scanning and empties
// the buffer; no word is lost or repeated across a stall.
module json_field_value_extractor_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast
);
    import jfve_pkg::*;

    step_out_t step;
    logic      accept;
    logic      has_room;

    // take a byte only when its worst-case burst fits in the queue
    assign s_axis_tready = has_room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    jfve_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_axis_tdata),
        .step    (step)
    );

    jfve_res_fifo u_res_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .step      (step),
        .has_room  (has_room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import jfve_pkg::*;

    localparam int RANDOM_BYTES = 460;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_PRINTS   = 30;

    // receiver stall styles
    localparam logic [1:0] RX_ALWAYS = 2'd0;
    localparam logic [1:0] RX_SPOTTY = 2'd1;
    localparam logic [1:0] RX_RUNS   = 2'd2;

    // the two keys of interest, first character in the top byte
    localparam logic [39:0] TITLE_WORD   = "title";
    localparam logic [55:0] EXTRACT_WORD = "extract";

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } value_word_t;

    logic       clk;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    // parser state of the predictor
    mode_t       ps_mode       = MODE_SCAN;
    logic        ps_esc        = 1'b0;
    logic [3:0]  ps_key_pos    = 4'd0;
    logic        ps_title_ok   = 1'b0;
    logic        ps_extract_ok = 1'b0;
    logic        ps_in_extract = 1'b0;
    logic        ps_line_dirty = 1'b0;
    logic [15:0] ps_hex        = 16'h0000;
    logic [1:0]  ps_hex_cnt    = 2'd0;

    value_word_t step_words[$];
    value_word_t decoded_words_due[$];
    logic [7:0]  byte_queue[$];

    int   error_count   = 0;
    int   bytes_queued  = 0;
    int   bytes_taken   = 0;
    int   words_checked = 0;
    int   cycle_count   = 0;
    int   kind_seen[4]  = '{0, 0, 0, 0};
    logic input_taken   = 1'b0;

    // sender burst shaping
    int gap_left   = 0;
    int burst_left = 0;

    // receiver stall shaping
    logic [1:0] stall_style = RX_ALWAYS;
    int         style_left  = 0;
    int         stall_run   = 0;

    json_field_value_extractor_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Append one word for the current input byte; at most three per byte.
    function automatic void emit_word(input logic [1:0] kind, input logic [7:0] data);
        value_word_t w;
        if (step_words.size() >= MAX_RESULTS)
        begin
            return;
        end
        w.kind = kind;
        w.data = data;
        w.last = 1'b0;
        step_words = {step_words, w};
    endfunction

    function automatic void emit_value_byte(input logic [7:0] data);
        if (ps_in_extract)
        begin
            emit_word(KIND_EXTRACT, data);
            ps_line_dirty = 1'b1;
        end
        else
        begin
            emit_word(KIND_TITLE, data);
        end
    endfunction

    function automatic void end_line();
        emit_word(KIND_LINE_END, 8'h00);
        ps_line_dirty = 1'b0;
    endfunction

    // Compare one key byte against both keys at the current position.
    function automatic void match_key_byte(input logic [7:0] ch);
        int p;
        p = ps_key_pos;
        if (p >= 5)
        begin
            ps_title_ok = 1'b0;
        end
        else if (TITLE_WORD[8*(4-p) +: 8] != ch)
        begin
            ps_title_ok = 1'b0;
        end
        if (p >= 7)
        begin
            ps_extract_ok = 1'b0;
        end
        else if (EXTRACT_WORD[8*(6-p) +: 8] != ch)
        begin
            ps_extract_ok = 1'b0;
        end
        if (ps_key_pos < KEY_POS_MAX)
        begin
            ps_key_pos++;
        end
    endfunction

    function automatic logic is_blank(input logic [7:0] ch);
        return (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

    // Value of a hex digit, or -1 if the byte is not one.
    function automatic int nibble_of(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9")
        begin
            return int'(ch) - int'("0");
        end
        if (ch >= "a" && ch <= "f")
        begin
            return int'(ch) - int'("a") + 10;
        end
        if (ch >= "A" && ch <= "F")
        begin
            return int'(ch) - int'("A") + 10;
        end
        return -1;
    endfunction

    // Advance the parser by one input byte and queue the words it causes.
    task automatic parse_json_byte(input logic [7:0] ch);
        int          d;
        logic [15:0] cp;
        step_words.delete();
        case (ps_mode)
            MODE_KEY:
            begin
                if (ps_esc)
                begin
                    match_key_byte(ch);
                    ps_esc = 1'b0;
                end
                else if (ch == CH_BSLASH)
                begin
                    ps_esc = 1'b1;
                end
                else if (ch == CH_QUOTE)
                begin
                    ps_title_ok   = ps_title_ok && (ps_key_pos == TITLE_LEN);
                    ps_extract_ok = ps_extract_ok && (ps_key_pos == EXTRACT_LEN);
                    ps_mode       = MODE_AFTER_KEY;
                end
                else
                begin
                    match_key_byte(ch);
                end
            end
            MODE_AFTER_KEY:
            begin
                if (!is_blank(ch))
                begin
                    ps_mode = (ch == CH_COLON) ? MODE_EXPECT_VALUE : MODE_SCAN;
                end
            end
            MODE_EXPECT_VALUE:
            begin
                if (!is_blank(ch))
                begin
                    if (ch == CH_QUOTE)
                    begin
                        ps_esc        = 1'b0;
                        ps_line_dirty = 1'b0;
                        if (ps_title_ok || ps_extract_ok)
                        begin
                            ps_in_extract = ps_extract_ok;
                            ps_mode       = MODE_IN_VALUE;
                        end
                        else
                        begin
                            ps_mode = MODE_SKIP_VALUE;
                        end
                    end
                    else
                    begin
                        ps_mode = MODE_SCAN;
                    end
                end
            end
            MODE_SKIP_VALUE:
            begin
                if (ps_esc)
                begin
                    ps_esc = 1'b0;
                end
                else if (ch == CH_BSLASH)
                begin
                    ps_esc = 1'b1;
                end
                else if (ch == CH_QUOTE)
                begin
                    ps_mode = MODE_SCAN;
                end
            end
            MODE_IN_VALUE:
            begin
                if (ps_esc)
                begin
                    ps_esc = 1'b0;
                    if (ch == CH_LOW_U)
                    begin
                        ps_hex     = 16'h0000;
                        ps_hex_cnt = 2'd0;
                        ps_mode    = MODE_HEX;
                    end
                    else if (ch == CH_LOW_N)
                    begin
                        if (ps_in_extract)
                        begin
                            end_line();
                        end
                        else
                        begin
                            emit_value_byte(CH_LF);
                        end
                    end
                    else if (ch == CH_LOW_R)
                    begin
                        emit_value_byte(CH_CR);
                    end
                    else if (ch == CH_LOW_T)
                    begin
                        emit_value_byte(CH_TAB);
                    end
                    else if (ch == CH_LOW_B)
                    begin
                        emit_value_byte(CH_BS);
                    end
                    else if (ch == CH_LOW_F)
                    begin
                        emit_value_byte(CH_FF);
                    end
                    else
                    begin
                        // unknown escape: pass the byte through
                        emit_value_byte(ch);
                    end
                end
                else if (ch == CH_BSLASH)
                begin
                    ps_esc = 1'b1;
                end
                else if (ch == CH_QUOTE)
                begin
                    if (ps_in_extract)
                    begin
                        if (ps_line_dirty)
                        begin
                            end_line();
                        end
                    end
                    else
                    begin
                        emit_word(KIND_TITLE_DONE, 8'h00);
                    end
                    ps_mode = MODE_SCAN;
                end
                else if (ps_in_extract && ch == CH_LF)
                begin
                    end_line();
                end
                else
                begin
                    emit_value_byte(ch);
                end
            end
            MODE_HEX:
            begin
                d = nibble_of(ch);
                if (d < 0)
                begin
                    // drop the whole escape, stay in the string
                    ps_hex     = 16'h0000;
                    ps_hex_cnt = 2'd0;
                    ps_mode    = MODE_IN_VALUE;
                end
                else if (ps_hex_cnt < 2'd3)
                begin
                    ps_hex = {ps_hex[11:0], d[3:0]};
                    ps_hex_cnt++;
                end
                else
                begin
                    cp = {ps_hex[11:0], d[3:0]};
                    if (cp < 16'h0080)
                    begin
                        emit_value_byte(cp[7:0]);
                    end
                    else if (cp < 16'h0800)
                    begin
                        emit_value_byte(UTF8_LEAD2 | {3'b000, cp[10:6]});
                        emit_value_byte(UTF8_CONT | {2'b00, cp[5:0]});
                    end
                    else
                    begin
                        emit_value_byte(UTF8_LEAD3 | {4'h0, cp[15:12]});
                        emit_value_byte(UTF8_CONT | {2'b00, cp[11:6]});
                        emit_value_byte(UTF8_CONT | {2'b00, cp[5:0]});
                    end
                    ps_hex     = 16'h0000;
                    ps_hex_cnt = 2'd0;
                    ps_mode    = MODE_IN_VALUE;
                end
            end
            default:
            begin
                ps_mode = MODE_SCAN;
                if (ch == CH_QUOTE)
                begin
                    ps_key_pos    = 4'd0;
                    ps_title_ok   = 1'b1;
                    ps_extract_ok = 1'b1;
                    ps_esc        = 1'b0;
                    ps_mode       = MODE_KEY;
                end
            end
        endcase
        if (step_words.size() > 0)
        begin
            step_words[step_words.size() - 1].last = 1'b1;
        end
        foreach (step_words[i])
        begin
            decoded_words_due = {decoded_words_due, step_words[i]};
        end
    endtask

    // ---------------------------------------------------------------
    // Stimulus building
    // ---------------------------------------------------------------

    task automatic add_byte(input logic [7:0] b);
        byte_queue = {byte_queue, b};
        bytes_queued++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            add_byte(s[i]);
        end
    endtask

    // Hex digit character, upper or lower case at random.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return 8'h30 + {4'h0, nib};
        end
        if ($urandom_range(0, 1) == 0)
        begin
            return 8'h41 + {4'h0, nib} - 8'd10;
        end
        return 8'h61 + {4'h0, nib} - 8'd10;
    endfunction

    // Random byte that is not a hex digit (bad \u digit).
    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:       b = CH_QUOTE;
            1:       b = CH_BSLASH;
            default: b = 8'($urandom_range(0, 255));
        endcase
        while (nibble_of(b) >= 0)
        begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    task automatic add_blanks();
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 5))
                0:       add_byte(CH_TAB);
                1:       add_byte(CH_LF);
                2:       add_byte(CH_CR);
                3:       add_byte(8'h0B);
                4:       add_byte(CH_FF);
                default: add_byte(CH_SPACE);
            endcase
        end
    endtask

    task automatic add_unicode_escape();
        logic [15:0] cp;
        case ($urandom_range(0, 7))
            0:       cp = 16'h000A;
            1, 2:    cp = 16'($urandom_range(0, 16'h007F));
            3, 4:    cp = 16'($urandom_range(16'h0080, 16'h07FF));
            default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        add_text("\\u");
        add_byte(hex_char(cp[15:12]));
        add_byte(hex_char(cp[11:8]));
        add_byte(hex_char(cp[7:4]));
        add_byte(hex_char(cp[3:0]));
    endtask

    // String body: plain bytes, raw newlines, escapes, good and bad \u.
    task automatic add_string_value();
        logic [7:0] b;
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 10))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    b = 8'($urandom_range(8'h20, 8'h7E));
                    if (b == CH_QUOTE || b == CH_BSLASH)
                    begin
                        b = "x";
                    end
                    add_byte(b);
                end
                4:
                begin
                    add_byte(CH_LF);
                end
                5:
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_QUOTE || b == CH_BSLASH)
                    begin
                        b = 8'hFF;
                    end
                    add_byte(b);
                end
                6:
                begin
                    add_byte(CH_BSLASH);
                    case ($urandom_range(0, 9))
                        0:       add_byte(CH_LOW_N);
                        1:       add_byte(CH_LOW_R);
                        2:       add_byte(CH_LOW_T);
                        3:       add_byte(CH_LOW_B);
                        4:       add_byte(CH_LOW_F);
                        5:       add_byte(CH_QUOTE);
                        6:       add_byte(CH_BSLASH);
                        7:       add_byte("/");
                        8:       add_byte(8'h00);
                        default: add_byte(8'($urandom_range(0, 255)));
                    endcase
                end
                7, 8:
                begin
                    add_unicode_escape();
                end
                default:
                begin
                    // broken \u: up to three good digits, then a bad one
                    add_text("\\u");
                    repeat ($urandom_range(0, 3))
                    begin
                        add_byte(hex_char(4'($urandom_range(0, 15))));
                    end
                    add_byte(non_hex_byte());
                end
            endcase
        end
        add_byte(CH_QUOTE);
    endtask

    // One key/value member, mostly the keys of interest.
    task automatic add_member();
        logic [7:0] b;
        add_byte(CH_QUOTE);
        case ($urandom_range(0, 9))
            0, 1, 2: add_text("title");
            3, 4, 5: add_text("extract");
            6:
            begin
                // escaped key bytes compare as plain bytes
                case ($urandom_range(0, 2))
                    0:       add_text("ti\\tle");
                    1:       add_text("\\extract");
                    default: add_text("extr\\\"ct");
                endcase
            end
            7:
            begin
                case ($urandom_range(0, 4))
                    0:       add_text("titles");
                    1:       add_text("titl");
                    2:       add_text("extracts");
                    3:       add_text("Title");
                    default: add_text("ext");
                endcase
            end
            8:
            begin
                // long key; most lengths saturate the position counter
                repeat ($urandom_range(14, 20))
                begin
                    add_byte(8'($urandom_range(8'h61, 8'h7A)));
                end
            end
            default:
            begin
                repeat ($urandom_range(0, 6))
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_QUOTE || b == CH_BSLASH)
                    begin
                        b = 8'h41;
                    end
                    add_byte(b);
                end
            end
        endcase
        add_byte(CH_QUOTE);
        add_blanks();
        if ($urandom_range(0, 11) == 0)
        begin
            // wrong byte after the key, sometimes a quote
            if ($urandom_range(0, 2) == 0)
            begin
                b = CH_QUOTE;
            end
            else
            begin
                b = 8'($urandom_range(0, 255));
                while (is_blank(b) || b == CH_COLON)
                begin
                    b = 8'($urandom_range(0, 255));
                end
            end
            add_byte(b);
            return;
        end
        add_byte(CH_COLON);
        add_blanks();
        if ($urandom_range(0, 7) == 0)
        begin
            // value that is not a string
            case ($urandom_range(0, 4))
                0:       add_byte("1");
                1:       add_byte("n");
                2:       add_byte("{");
                3:       add_byte("[");
                default: add_byte("t");
            endcase
        end
        else
        begin
            add_string_value();
        end
        case ($urandom_range(0, 2))
            0:       add_byte(",");
            1:       add_byte(CH_SPACE);
            default: add_byte(CH_LF);
        endcase
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 4))
        begin
            add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Hold until the sender is empty and every predicted word has come back.
    task automatic wait_for_drain();
        while (byte_queue.size() != 0 || s_axis_tvalid || decoded_words_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ---------------------------------------------------------------
    // Sender: bursts of random length with random gaps, changes at negedge
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin : drive_input
        logic       next_valid;
        logic [7:0] next_data;
        next_valid = s_axis_tvalid && !input_taken;
        next_data  = s_axis_tdata;
        if (rst_n && !next_valid)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (byte_queue.size() > 0)
            begin
                next_data  = byte_queue.pop_front();
                next_valid = 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        s_axis_tvalid <= next_valid;
        s_axis_tdata  <= next_data;
    end

    // ---------------------------------------------------------------
    // Receiver: switches between random stall styles
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin : drive_ready
        logic ready;
        if (style_left == 0)
        begin
            stall_style = 2'($urandom_range(0, 2));
            style_left  = $urandom_range(20, 200);
        end
        else
        begin
            style_left--;
        end
        case (stall_style)
            RX_SPOTTY:
            begin
                ready = ($urandom_range(0, 9) >= 3);
            end
            RX_RUNS:
            begin
                if (stall_run > 0)
                begin
                    stall_run--;
                    ready = 1'b0;
                end
                else if ($urandom_range(0, 5) == 0)
                begin
                    stall_run = $urandom_range(1, 8);
                    ready     = 1'b0;
                end
                else
                begin
                    ready = 1'b1;
                end
            end
            default:
            begin
                ready = 1'b1;
            end
        endcase
        m_axis_tready <= ready;
    end

    // ---------------------------------------------------------------
    // Monitor: predict on accepted input, check accepted output words
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : watch_ports
        value_word_t due;
        if (rst_n)
        begin
            input_taken = s_axis_tvalid && s_axis_tready;
            if (input_taken)
            begin
                bytes_taken++;
                parse_json_byte(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (decoded_words_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word kind %0d data %02h last %0b",
                                              m_axis_tuser, m_axis_tdata, m_axis_tlast));
                end
                else
                begin
                    due = decoded_words_due.pop_front();
                    words_checked++;
                    kind_seen[due.kind]++;
                    if (m_axis_tuser !== due.kind)
                    begin
                        report_mismatch($sformatf("word %0d kind %0d, want %0d",
                                                  words_checked, m_axis_tuser, due.kind));
                    end
                    if (m_axis_tdata !== due.data)
                    begin
                        report_mismatch($sformatf("word %0d data %02h, want %02h",
                                                  words_checked, m_axis_tdata, due.data));
                    end
                    if (m_axis_tlast !== due.last)
                    begin
                        report_mismatch($sformatf("word %0d last %0b, want %0b",
                                                  words_checked, m_axis_tlast, due.last));
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycle_count, decoded_words_due.size());
            $display("json_field_value_extractor_unit regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin : run_test
        int directed_bytes;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: title with three-byte and two-byte \u, raw 0xFF and 0x00,
        // escaped newline in a title, then the title end mark.
        add_text("\"title\" :\"\\uFFFF\\u07ff");
        add_byte(8'hFF);
        add_byte(8'h00);
        add_text("\\n\"");
        directed_bytes = bytes_queued;

        // pause the sender until every word of the directed part is back
        wait_for_drain();

        while (bytes_queued < directed_bytes + RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                add_member();
            end
            else
            begin
                add_noise();
            end
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (decoded_words_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d words never arrived", decoded_words_due.size()));
        end

        $display("covered %0d JSON bytes, %0d output words checked, %0d mismatches",
                 bytes_taken, words_checked, error_count);
        $display("words by kind: title %0d, extract %0d, line end %0d, title done %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        if (error_count == 0)
        begin
            $display("json_field_value_extractor_unit regression: pass");
        end
        else
        begin
            $display("json_field_value_extractor_unit regression: fail");
        end
        $finish;
    end

endmodule
